// ----- hdl/path_point_generator_defines.svh -----
// Assertion macros shared by the path point generator.
`ifndef PATH_POINT_GENERATOR_DEFINES_SVH
`define PATH_POINT_GENERATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPG_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("path_point_generator: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("path_point_generator: next-cycle check failed");

`endif

// ----- hdl/ppg_pkg.sv -----
// Types, constants and microcode encoding of the path point generator.
package ppg_pkg;

  // Phase and coordinate formats
  localparam int PHASE_W = 16;
  localparam int COORD_W = 16;
  localparam int POINT_W = 3 * COORD_W;

  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [POINT_W-1:0] point_t;

  localparam phase_t PHASE_STEP_RESET = 16'd328;
  localparam coord_t COORD_BIAS       = 16'h8000;

  // Shared multiplier and accumulator widths
  localparam int MUL_A_W = 49;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int W_W     = 49;
  localparam int ACC_W   = 64;

  localparam logic [ACC_W-1:0] ROUND_HALF = 64'h0000_8000_0000_0000;

  // Loop bounds of the blend
  localparam logic [1:0] LAST_PT    = 2'd3;
  localparam logic [1:0] LAST_COORD = 2'd2;

  // Register map
  typedef enum logic [2:0] {
    REG_CURVE_MODE      = 3'd0,
    REG_PHASE_STEP      = 3'd1,
    REG_START_POINT     = 3'd2,
    REG_CONTROL_POINT_A = 3'd3,
    REG_CONTROL_POINT_B = 3'd4,
    REG_END_POINT       = 3'd5
  } reg_idx_t;

  // Micro-program counter
  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] upc_t;

  localparam upc_t PROG_CURVE  = 4'd0;
  localparam upc_t PROG_LINEAR = 4'd7;
  localparam upc_t STEP_BLEND  = 4'd8;

  // Control word fields
  typedef enum logic [2:0] {
    A_U, A_T, A_T3, A_UU, A_TT, A_TU3, A_W
  } a_sel_t;

  typedef enum logic [1:0] {
    B_U, B_T, B_P
  } b_sel_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_UU, DST_TT, DST_TU3, DST_W0, DST_W1, DST_W2, DST_W3, DST_LIN, DST_PROD
  } dst_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_INIT, ACC_MAC, ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD, CNT_CLEAR, CNT_PT, CNT_COORD
  } cnt_op_t;

  typedef enum logic [2:0] {
    JMP_NEXT, JMP_ALWAYS, JMP_PT_MORE, JMP_COORD_MORE, JMP_FINISH
  } jmp_t;

  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    dst_t    dst;
    acc_op_t acc_op;
    cnt_op_t cnt_op;
    logic    store;
    jmp_t    jmp;
    upc_t    target;
  } uword_t;

  localparam uword_t UW_NOP = '{A_U, B_U, DST_NONE, ACC_HOLD, CNT_HOLD, 1'b0, JMP_NEXT, '0};

  // Control from sequencer to datapath
  typedef struct packed {
    uword_t     uw;
    logic [1:0] pt;
    logic [1:0] coord;
  } ppg_ctrl_t;

endpackage

// ----- hdl/path_point_generator.sv -----
// Top level of the path point generator: register port, phase, handshakes.
//
// Each word accepted on the input channel (in_valid high, in_stall low) is one
// tick. With advance set the Q0.16 phase first grows by phase_step and wraps to
// zero on reaching one; the block then gives one output word holding the Q8.8
// point at that phase and the phase itself (pos_x, pos_y, pos_z, phase_out).
// Curve mode blends start, both control points and end with cubic Bernstein
// weights; straight mode blends start and end only.
// in_stall is high while a word is in work; it drops at the edge that loads the
// output word, and the next word can be taken from then on, so words are not
// overlapped. The micro-program runs one step per cycle but holds at its last
// step while the output register is full; its steps share the single 49 x 17
// multiplier, twelve blend products per point.
// The output register holds a finished word while out_stall is high; a new
// word is accepted meanwhile, and its evaluation waits at its last step until
// the register is free. Reset clears the phase, loads the register defaults
// (phase_step 328, all else zero) and empties both channels.
// The APB port writes registers at byte address 8 * index, 64-bit data.
`include "path_point_generator_defines.svh"

module path_point_generator (
  input  logic                  clk,
  input  logic                  rst,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [5:0]            paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready,
  // tick channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  advance,
  // point channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    pos_x,
  output logic signed [15:0]    pos_y,
  output logic signed [15:0]    pos_z,
  output ppg_pkg::phase_t       phase_out
);
  import ppg_pkg::*;

  logic                 curve_mode;
  phase_t               phase_step;
  point_t               start_point;
  point_t               control_point_a;
  point_t               control_point_b;
  point_t               end_point;
  phase_t               phase;
  phase_t               phase_next;
  logic [PHASE_W:0]     phase_sum;
  reg_idx_t             reg_idx;
  logic                 cfg_wr;
  logic                 in_accept;
  logic                 busy;
  logic                 load_out;
  logic                 out_free;
  ppg_ctrl_t            ctrl;
  point_t [3:0]         pts;
  coord_t               res_x;
  coord_t               res_y;
  coord_t               res_z;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode      <= 1'b0;
      phase_step      <= PHASE_STEP_RESET;
      start_point     <= '0;
      control_point_a <= '0;
      control_point_b <= '0;
      end_point       <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CURVE_MODE:      curve_mode      <= pwdata[0];
        REG_PHASE_STEP:      phase_step      <= pwdata[PHASE_W-1:0];
        REG_START_POINT:     start_point     <= pwdata[POINT_W-1:0];
        REG_CONTROL_POINT_A: control_point_a <= pwdata[POINT_W-1:0];
        REG_CONTROL_POINT_B: control_point_b <= pwdata[POINT_W-1:0];
        REG_END_POINT:       end_point       <= pwdata[POINT_W-1:0];
        default:             ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (reg_idx)
      REG_CURVE_MODE:      prdata = 64'(curve_mode);
      REG_PHASE_STEP:      prdata = 64'(phase_step);
      REG_START_POINT:     prdata = 64'(start_point);
      REG_CONTROL_POINT_A: prdata = 64'(control_point_a);
      REG_CONTROL_POINT_B: prdata = 64'(control_point_b);
      REG_END_POINT:       prdata = 64'(end_point);
      default:             prdata = '0;
    endcase
  end

  // Step the phase on an accepted tick with advance set; wrap to zero on reaching one
  assign in_stall   = busy;
  assign in_accept  = in_valid && !in_stall;
  assign phase_sum  = {1'b0, phase} + {1'b0, phase_step};
  assign phase_next = phase_sum[PHASE_W] ? '0 : phase_sum[PHASE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (in_accept && advance) begin
      phase <= phase_next;
    end
  end

  assign pts = {end_point, control_point_b, control_point_a, start_point};

  ppg_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_accept),
    .curve    (curve_mode),
    .out_free (out_free),
    .busy     (busy),
    .load_out (load_out),
    .ctrl     (ctrl)
  );

  ppg_datapath u_dp (
    .clk   (clk),
    .ctrl  (ctrl),
    .t     (phase),
    .pts   (pts),
    .res_x (res_x),
    .res_y (res_y),
    .res_z (res_z)
  );

  // Output register: hold the word while the receiver stalls
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pos_x     <= $signed(res_x);
      pos_y     <= $signed(res_y);
      pos_z     <= $signed(res_z);
      phase_out <= phase;
    end
  end

  // Phase moves only on an accepted tick
  `PPG_ASSERT_NEXT(a_phase_held, clk, rst, !in_accept, $stable(phase))
  // A word in work is not abandoned before its hand-over
  `PPG_ASSERT_NEXT(a_busy_until_load, clk, rst, busy && !load_out, busy)
  // Hand-over fills the output register with the phase in use
  `PPG_ASSERT_NEXT(a_load_fills, clk, rst, load_out, out_valid && (phase_out == $past(phase)))

endmodule

// ----- hdl/ppg_ucode_rom.sv -----
// Micro-program store: one control word per step of the point evaluation.
module ppg_ucode_rom (
  input  ppg_pkg::upc_t   pc,
  output ppg_pkg::uword_t uw
);
  import ppg_pkg::*;

  // Curve entry forms the Bernstein weights, linear entry forms lerp weights,
  // both then run the shared blend loop over three coordinates.
  always_comb begin
    unique case (pc)
      4'd0:    uw = '{A_U,   B_U, DST_UU,   ACC_HOLD, CNT_HOLD,  1'b0, JMP_NEXT, '0};
      4'd1:    uw = '{A_T,   B_T, DST_TT,   ACC_HOLD, CNT_HOLD,  1'b0, JMP_NEXT, '0};
      4'd2:    uw = '{A_T3,  B_U, DST_TU3,  ACC_HOLD, CNT_HOLD,  1'b0, JMP_NEXT, '0};
      4'd3:    uw = '{A_UU,  B_U, DST_W0,   ACC_HOLD, CNT_HOLD,  1'b0, JMP_NEXT, '0};
      4'd4:    uw = '{A_TU3, B_U, DST_W1,   ACC_HOLD, CNT_HOLD,  1'b0, JMP_NEXT, '0};
      4'd5:    uw = '{A_TU3, B_T, DST_W2,   ACC_HOLD, CNT_HOLD,  1'b0, JMP_NEXT, '0};
      4'd6:    uw = '{A_TT,  B_T, DST_W3,   ACC_INIT, CNT_CLEAR, 1'b0, JMP_ALWAYS,
                      STEP_BLEND};
      4'd7:    uw = '{A_U,   B_U, DST_LIN,  ACC_INIT, CNT_CLEAR, 1'b0, JMP_NEXT, '0};
      4'd8:    uw = '{A_W,   B_P, DST_PROD, ACC_MAC,  CNT_PT,    1'b0, JMP_PT_MORE,
                      STEP_BLEND};
      4'd9:    uw = '{A_U,   B_U, DST_NONE, ACC_ADD,  CNT_HOLD,  1'b0, JMP_NEXT, '0};
      4'd10:   uw = '{A_U,   B_U, DST_NONE, ACC_INIT, CNT_COORD, 1'b1, JMP_COORD_MORE,
                      STEP_BLEND};
      4'd11:   uw = '{A_U,   B_U, DST_NONE, ACC_HOLD, CNT_HOLD,  1'b0, JMP_FINISH, '0};
      default: uw = UW_NOP;
    endcase
  end

endmodule

// ----- hdl/ppg_sequencer.sv -----
// Step counter, loop counters and jump logic that walk the micro-program.
module ppg_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               curve,
  input  logic               out_free,
  output logic               busy,
  output logic               load_out,
  output ppg_pkg::ppg_ctrl_t ctrl
);
  import ppg_pkg::*;

  upc_t       pc;
  upc_t       pc_next;
  logic [1:0] pt;
  logic [1:0] coord;
  uword_t     uw;

  ppg_ucode_rom u_rom (
    .pc (pc),
    .uw (uw)
  );

  // Pick the next step from the jump field
  always_comb begin
    unique case (uw.jmp)
      JMP_NEXT:       pc_next = upc_t'(pc + 1'b1);
      JMP_ALWAYS:     pc_next = uw.target;
      JMP_PT_MORE:    pc_next = (pt != LAST_PT) ? uw.target : upc_t'(pc + 1'b1);
      JMP_COORD_MORE: pc_next = (coord != LAST_COORD) ? uw.target : upc_t'(pc + 1'b1);
      JMP_FINISH:     pc_next = pc;
      default:        pc_next = pc;
    endcase
  end

  // Hand the finished point over once the output register is free
  assign load_out = busy && (uw.jmp == JMP_FINISH) && out_free;

  // Drive the datapath only while a word is in work
  assign ctrl.uw    = busy ? uw : UW_NOP;
  assign ctrl.pt    = pt;
  assign ctrl.coord = coord;

  // Advance the step counter and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      pc    <= PROG_CURVE;
      pt    <= '0;
      coord <= '0;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        pc   <= curve ? PROG_CURVE : PROG_LINEAR;
      end
    end else begin
      if (load_out) begin
        busy <= 1'b0;
      end
      pc <= pc_next;
      unique case (uw.cnt_op)
        CNT_CLEAR: begin
          pt    <= '0;
          coord <= '0;
        end
        CNT_PT:    pt    <= pt + 1'b1;
        CNT_COORD: coord <= coord + 1'b1;
        default:   ;
      endcase
    end
  end

endmodule

// ----- hdl/ppg_datapath.sv -----
// Weight registers, shared multiplier, accumulator and result registers.
module ppg_datapath (
  input  logic                     clk,
  input  ppg_pkg::ppg_ctrl_t       ctrl,
  input  ppg_pkg::phase_t          t,
  input  ppg_pkg::point_t [3:0]    pts,
  output ppg_pkg::coord_t          res_x,
  output ppg_pkg::coord_t          res_y,
  output ppg_pkg::coord_t          res_z
);
  import ppg_pkg::*;

  localparam int UU_W  = 33;
  localparam int TT_W  = 32;
  localparam int TU3_W = 34;

  logic [MUL_B_W-1:0]   u;
  logic [PHASE_W+1:0]   t3;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]   mul_res;
  logic [UU_W-1:0]      uu;
  logic [TT_W-1:0]      tt;
  logic [TU3_W-1:0]     tu3;
  logic [W_W-1:0]       w [4];
  logic [ACC_W-1:0]     prod;
  logic [ACC_W-1:0]     acc;
  point_t               pt_sel;
  coord_t               coord_sel;

  // One minus phase, and three times phase
  assign u  = {1'b1, {PHASE_W{1'b0}}} - {1'b0, t};
  assign t3 = {1'b0, t, 1'b0} + {2'b00, t};

  // Take the current coordinate of the current point; it is offset to unsigned at the multiplier input
  assign pt_sel = pts[ctrl.pt];
  always_comb begin
    case (ctrl.coord)
      2'd0:    coord_sel = pt_sel[POINT_W-1 -: COORD_W];
      2'd1:    coord_sel = pt_sel[2*COORD_W-1 -: COORD_W];
      default: coord_sel = pt_sel[COORD_W-1:0];
    endcase
  end

  // Multiplier operand selection
  always_comb begin
    unique case (ctrl.uw.a_sel)
      A_U:     mul_a = MUL_A_W'(u);
      A_T:     mul_a = MUL_A_W'(t);
      A_T3:    mul_a = MUL_A_W'(t3);
      A_UU:    mul_a = MUL_A_W'(uu);
      A_TT:    mul_a = MUL_A_W'(tt);
      A_TU3:   mul_a = MUL_A_W'(tu3);
      A_W:     mul_a = w[ctrl.pt];
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (ctrl.uw.b_sel)
      B_U:     mul_b = u;
      B_T:     mul_b = {1'b0, t};
      B_P:     mul_b = {1'b0, coord_sel ^ COORD_BIAS};
      default: mul_b = '0;
    endcase
  end

  assign mul_res = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

  // Latch the product into its destination
  always_ff @(posedge clk) begin
    unique case (ctrl.uw.dst)
      DST_UU:   uu   <= mul_res[UU_W-1:0];
      DST_TT:   tt   <= mul_res[TT_W-1:0];
      DST_TU3:  tu3  <= mul_res[TU3_W-1:0];
      DST_W0:   w[0] <= mul_res[W_W-1:0];
      DST_W1:   w[1] <= mul_res[W_W-1:0];
      DST_W2:   w[2] <= mul_res[W_W-1:0];
      DST_W3:   w[3] <= mul_res[W_W-1:0];
      DST_LIN: begin
        w[0] <= {u, 32'b0};
        w[1] <= '0;
        w[2] <= '0;
        w[3] <= {1'b0, t, 32'b0};
      end
      DST_PROD: prod <= mul_res[ACC_W-1:0];
      default:  ;
    endcase
  end

  // Accumulate products; skip the stale product at the head of each coordinate
  always_ff @(posedge clk) begin
    unique case (ctrl.uw.acc_op)
      ACC_INIT: acc <= ROUND_HALF;
      ACC_MAC: begin
        if (ctrl.pt != 2'd0) begin
          acc <= acc + prod;
        end
      end
      ACC_ADD:  acc <= acc + prod;
      default:  ;
    endcase
  end

  // Drop the fraction and the offset, store the coordinate
  always_ff @(posedge clk) begin
    if (ctrl.uw.store) begin
      case (ctrl.coord)
        2'd0:    res_x <= acc[ACC_W-1 -: COORD_W] ^ COORD_BIAS;
        2'd1:    res_y <= acc[ACC_W-1 -: COORD_W] ^ COORD_BIAS;
        default: res_z <= acc[ACC_W-1 -: COORD_W] ^ COORD_BIAS;
      endcase
    end
  end

endmodule
